FILE: design/lru_page_replacement_unit_macros.svh
// Assertion macros for the checker file of the LRU page-frame table.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define LPR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpr check failed");

// Free-form property body, sampled on the rising edge, quiet during reset.
`define LPR_ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lpr check failed");

`endif

FILE: design/lpr_pkg.sv
// Shared constants and types for the LRU page-frame table.
`timescale 1ns / 1ps
package lpr_pkg;

   localparam int FRAMES_DEFAULT    = 8;
   localparam int PAGE_BITS_DEFAULT = 16;
   localparam int FIU_BITS          = 4;
   localparam logic [FIU_BITS-1:0] FIU_RESET = 4'd8;
   localparam int FAULT_BITS        = 32;
   localparam int FRAME_OUT_BITS    = 3;
   localparam int CSR_DATA_BITS     = 32;
   localparam int CSR_ADDR_BITS     = 3;
   // register index, taken from paddr[2]
   localparam logic CSR_REG_FRAMES  = 1'b0;

   typedef struct packed {
      logic hit;
      logic fill;
      logic evict;
   } lpr_action_type;

endpackage

FILE: design/lru_page_replacement_unit.sv
// An item taken into the input register (in_valid_ff) has its result strobe registered
// from there in rsp_valid_ff.
// Throughput: one item per cycle; busy stays low, the table is updated in the same
// cycle the item leaves the input register, so the next item sees the new state.
// Reset (synchronous): all frames empty, ranks zero, fault count zero, frames_in_use 8.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module lru_page_replacement_unit import lpr_pkg::*; #(
   parameter int FRAMES    = FRAMES_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [PAGE_BITS-1:0]      req_page,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic [FRAME_OUT_BITS-1:0] rsp_frame,
   output logic                      rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]      rsp_evicted_page,
   output logic [FAULT_BITS-1:0]     rsp_fault_total,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  paddr,
   input  logic [CSR_DATA_BITS-1:0]  pwdata,
   output logic [CSR_DATA_BITS-1:0]  prdata,
   output logic                      pready
);

   localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   logic                  in_valid_ff;
   logic [PAGE_BITS-1:0]  in_page_ff;
   logic [FIU_BITS-1:0]   frames_ff;
   logic [FRAMES-1:0]     valid_ff;
   logic [IDX_BITS-1:0]   rank_ff [FRAMES];
   logic [PAGE_BITS-1:0]  page_ff [FRAMES];
   logic [FAULT_BITS-1:0] fault_ff;
   logic [FAULT_BITS-1:0] fault_in;

   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic [FRAME_OUT_BITS-1:0] rsp_frame_ff;
   logic                      rsp_evicted_valid_ff;
   logic [PAGE_BITS-1:0]      rsp_evicted_page_ff;
   logic [FAULT_BITS-1:0]     rsp_fault_total_ff;

   lpr_action_type        action;
   logic [IDX_BITS-1:0]   target;
   logic [FRAMES-1:0]     valid_in;
   logic [IDX_BITS-1:0]   rank_in [FRAMES];
   logic                  csr_write;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_REG_FRAMES) ? CSR_DATA_BITS'(frames_ff) : '0;

   lpr_select #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_select (
      .page          (in_page_ff),
      .resident      (page_ff),
      .valid         (valid_ff),
      .rank          (rank_ff),
      .frames_in_use (frames_ff),
      .action        (action),
      .target        (target)
   );

   lpr_rank #(
      .FRAMES (FRAMES)
   ) u_rank (
      .action   (action),
      .target   (target),
      .valid    (valid_ff),
      .rank     (rank_ff),
      .valid_in (valid_in),
      .rank_in  (rank_in)
   );

   // saturating fault count
   always_comb begin
      fault_in = fault_ff;
      if (!action.hit && fault_ff != '1) begin
         fault_in = fault_ff + FAULT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         frames_ff    <= FIU_RESET;
         valid_ff     <= '0;
         fault_ff     <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= start && !busy;
         rsp_valid_ff <= in_valid_ff;
         if (csr_write && paddr[2] == CSR_REG_FRAMES) begin
            frames_ff <= pwdata[FIU_BITS-1:0];
         end
         if (in_valid_ff) begin
            valid_ff <= valid_in;
            rank_ff  <= rank_in;
            fault_ff <= fault_in;
         end
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_page_ff <= req_page;
      end
      if (in_valid_ff) begin
         if (!action.hit) begin
            page_ff[target] <= in_page_ff;
         end
         rsp_hit_ff           <= action.hit;
         rsp_frame_ff         <= FRAME_OUT_BITS'(target);
         rsp_evicted_valid_ff <= action.evict;
         rsp_evicted_page_ff  <= action.evict ? page_ff[target] : '0;
         rsp_fault_total_ff   <= fault_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame         = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_total   = rsp_fault_total_ff;

endmodule

FILE: design/lpr_select.sv
// Parallel tag compare, empty-frame search and LRU victim choice.
`timescale 1ns / 1ps
module lpr_select import lpr_pkg::*; #(
   parameter int FRAMES    = FRAMES_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  logic [PAGE_BITS-1:0] page,
   input  logic [PAGE_BITS-1:0] resident [FRAMES],
   input  logic [FRAMES-1:0]    valid,
   input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rank [FRAMES],
   input  logic [FIU_BITS-1:0]  frames_in_use,
   output lpr_action_type       action,
   output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] target
);

   localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CMP_BITS = (IDX_BITS + 1 > FIU_BITS) ? IDX_BITS + 1 : FIU_BITS;

   logic [FRAMES-1:0] in_use;

   // a count of zero behaves as one; counts above FRAMES simply enable all
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         in_use[i] = (CMP_BITS'(i) < CMP_BITS'(frames_in_use)) || (i == 0);
      end
   end

   always_comb begin
      logic                hit_found;
      logic                empty_found;
      logic [IDX_BITS-1:0] hit_idx;
      logic [IDX_BITS-1:0] empty_idx;
      logic [IDX_BITS-1:0] victim_idx;
      logic [IDX_BITS-1:0] best;
      hit_found   = 1'b0;
      empty_found = 1'b0;
      hit_idx     = '0;
      empty_idx   = '0;
      victim_idx  = '0;
      best        = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (!hit_found && in_use[i] && valid[i] && resident[i] == page) begin
            hit_found = 1'b1;
            hit_idx   = IDX_BITS'(i);
         end
         if (!empty_found && in_use[i] && !valid[i]) begin
            empty_found = 1'b1;
            empty_idx   = IDX_BITS'(i);
         end
         // strict compare keeps the lowest index on a tie
         if (in_use[i] && rank[i] > best) begin
            best       = rank[i];
            victim_idx = IDX_BITS'(i);
         end
      end
      action.hit   = hit_found;
      action.fill  = !hit_found && empty_found;
      action.evict = !hit_found && !empty_found;
      if (hit_found) begin
         target = hit_idx;
      end else if (empty_found) begin
         target = empty_idx;
      end else begin
         target = victim_idx;
      end
   end

endmodule

FILE: design/lpr_rank.sv
// Next recency ranks and valid bits for one reference.
`timescale 1ns / 1ps
module lpr_rank import lpr_pkg::*; #(
   parameter int FRAMES = FRAMES_DEFAULT
) (
   input  lpr_action_type    action,
   input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] target,
   input  logic [FRAMES-1:0] valid,
   input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rank [FRAMES],
   output logic [FRAMES-1:0] valid_in,
   output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rank_in [FRAMES]
);

   localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   logic [IDX_BITS-1:0] pivot;

   assign pivot = rank[target];

   // ranks of valid frames stay a permutation of 0..k-1, so +1 never wraps
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         valid_in[i] = valid[i];
         rank_in[i]  = rank[i];
         if (action.fill) begin
            if (valid[i]) begin
               rank_in[i] = rank[i] + IDX_BITS'(1);
            end
         end else if (valid[i] && rank[i] < pivot) begin
            rank_in[i] = rank[i] + IDX_BITS'(1);
         end
         if (IDX_BITS'(i) == target) begin
            rank_in[i]  = '0;
            valid_in[i] = 1'b1;
         end
      end
   end

endmodule

FILE: design/lpr_checker.sv
// Port-level checks for the LRU page-frame table, bound to the top level.
`timescale 1ns / 1ps
`include "lru_page_replacement_unit_macros.svh"
module lpr_checker import lpr_pkg::*; #(
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic                  rsp_hit,
   input logic                  rsp_evicted_valid,
   input logic [PAGE_BITS-1:0]  rsp_evicted_page,
   input logic [FAULT_BITS-1:0] rsp_fault_total
);

   // a hit never evicts
   `LPR_ASSERT_IMPLY(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted_valid)
   // evicted page reads zero when nothing was replaced
   `LPR_ASSERT_IMPLY(a_evict_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0)
   // a fault has always been counted
   `LPR_ASSERT_IMPLY(a_fault_counted, clock, reset, rsp_valid && !rsp_hit, rsp_fault_total != '0)
   // every item gives exactly one result, and every result comes from an item
   `LPR_ASSERT_PROP(a_item_result, clock, reset, ((start && !busy) |-> ##2 rsp_valid))
   `LPR_ASSERT_PROP(a_result_item, clock, reset, (rsp_valid |-> $past(start && !busy, 2)))

endmodule

bind lru_page_replacement_unit lpr_checker #(.PAGE_BITS(PAGE_BITS)) u_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for the LRU page-frame table: directed table, then random references.
`timescale 1ns / 1ps
module tb_top;
   import lpr_pkg::*;

   localparam int PAGE_W      = PAGE_BITS_DEFAULT;
   localparam int FRAME_SLOTS = FRAMES_DEFAULT;
   localparam int PLAN_ROWS   = 24;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 150;
   localparam int DRAIN_WAIT  = 6;
   localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;

   typedef struct packed {
      logic                      hit;
      logic [FRAME_OUT_BITS-1:0] frame;
      logic                      evicted_valid;
      logic [PAGE_W-1:0]         evicted_page;
      logic [FAULT_BITS-1:0]     fault_total;
   } lookup_result_type;

   typedef struct packed {
      bit                  is_cfg;
      logic [FIU_BITS-1:0] fiu;
      logic [PAGE_W-1:0]   pg;
      bit                  typed;
      lookup_result_type   res;
   } plan_row_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [PAGE_W-1:0]         req_page;
   logic                      rsp_valid;
   logic                      rsp_hit;
   logic [FRAME_OUT_BITS-1:0] rsp_frame;
   logic                      rsp_evicted_valid;
   logic [PAGE_W-1:0]         rsp_evicted_page;
   logic [FAULT_BITS-1:0]     rsp_fault_total;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_BITS-1:0]  paddr;
   logic [CSR_DATA_BITS-1:0]  pwdata;
   logic [CSR_DATA_BITS-1:0]  prdata;
   logic                      pready;

   // predicted table state
   logic [PAGE_W-1:0]     page_held [FRAME_SLOTS];
   bit                    frame_full [FRAME_SLOTS];
   int unsigned           frame_age [FRAME_SLOTS];
   logic [FAULT_BITS-1:0] fault_tally;
   logic [FIU_BITS-1:0]   frames_setting;

   lookup_result_type pending_lookups [$];
   int                fail_count;
   plan_row_type      plan [PLAN_ROWS];
   logic [PAGE_W-1:0] hot_pages [12];

   lru_page_replacement_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_page(req_page),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_frame(rsp_frame),
      .rsp_evicted_valid(rsp_evicted_valid), .rsp_evicted_page(rsp_evicted_page),
      .rsp_fault_total(rsp_fault_total), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

   // frame f becomes most recent; valid frames newer than it age by one
   function automatic void make_recent(input int f);
      int unsigned r;
      r = frame_age[f];
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         if (i != f && frame_full[i] && frame_age[i] < r) frame_age[i]++;
      end
      frame_age[f] = 0;
   endfunction

   function automatic lookup_result_type lookup_page(input logic [PAGE_W-1:0] pg);
      lookup_result_type r;
      int n, tgt;
      int unsigned best;
      bit found, spare;
      r = '0;
      found = 0;
      spare = 0;
      tgt = 0;
      n = (frames_setting == 0) ? 1 :
          (frames_setting > FRAME_SLOTS) ? FRAME_SLOTS : int'(frames_setting);
      for (int i = 0; i < n; i++) begin
         if (!found && frame_full[i] && page_held[i] == pg) begin
            found = 1;
            tgt = i;
         end
      end
      if (found) begin
         make_recent(tgt);
      end else begin
         if (fault_tally != FAULT_MAX) fault_tally++;
         for (int i = 0; i < n; i++) begin
            if (!spare && !frame_full[i]) begin
               spare = 1;
               tgt = i;
            end
         end
         if (spare) begin
            for (int i = 0; i < FRAME_SLOTS; i++) begin
               if (frame_full[i] && frame_age[i] < 255) frame_age[i]++;
            end
            frame_full[tgt] = 1;
            frame_age[tgt] = 0;
            page_held[tgt] = pg;
         end else begin
            // oldest frame in use loses; ties go to the lowest index
            best = 0;
            tgt = 0;
            for (int i = 0; i < n; i++) begin
               if (frame_age[i] > best) begin
                  best = frame_age[i];
                  tgt = i;
               end
            end
            r.evicted_valid = 1'b1;
            r.evicted_page = page_held[tgt];
            page_held[tgt] = pg;
            make_recent(tgt);
         end
      end
      r.hit = found;
      r.frame = tgt[FRAME_OUT_BITS-1:0];
      r.fault_total = fault_tally;
      return r;
   endfunction

   function automatic plan_row_type chk(input logic [PAGE_W-1:0] pg, input logic h,
                                        input int fr, input logic ev,
                                        input logic [PAGE_W-1:0] evp, input int ft);
      plan_row_type row;
      row = '0;
      row.pg = pg;
      row.typed = 1;
      row.res.hit = h;
      row.res.frame = fr[FRAME_OUT_BITS-1:0];
      row.res.evicted_valid = ev;
      row.res.evicted_page = evp;
      row.res.fault_total = ft;
      return row;
   endfunction

   function automatic plan_row_type itm(input logic [PAGE_W-1:0] pg);
      plan_row_type row;
      row = '0;
      row.pg = pg;
      return row;
   endfunction

   function automatic plan_row_type cfg(input logic [FIU_BITS-1:0] v);
      plan_row_type row;
      row = '0;
      row.is_cfg = 1;
      row.fiu = v;
      return row;
   endfunction

   // called just after a rising edge; returns just after the edge that took the item
   task automatic send_page(input logic [PAGE_W-1:0] pg, input bit typed,
                            input lookup_result_type typed_res, input int idle_pct);
      lookup_result_type r;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_page <= pg;
      do @(posedge clock); while (busy);
      r = lookup_page(pg);
      pending_lookups = {pending_lookups, (typed ? typed_res : r)};
   endtask

   task automatic write_frames(input logic [FIU_BITS-1:0] v);
      start <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {CSR_REG_FRAMES, 2'b00};
      pwdata <= {(CSR_DATA_BITS - FIU_BITS)'($urandom), v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      frames_setting = v;
      // read back in the same selection
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata != CSR_DATA_BITS'(v)) begin
         $display("%0t frames_in_use readback: expected %0h actual %0h", $time, v, prdata);
         fail_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // results cannot be held off: every strobe is checked at the edge that ends it
   always @(posedge clock) begin
      lookup_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            $display("%0t result with nothing expected: hit %0b frame %0d", $time,
                     rsp_hit, rsp_frame);
            fail_count++;
         end else begin
            e = pending_lookups.pop_front();
            if (rsp_hit !== e.hit) begin
               $display("%0t hit: expected %0b actual %0b", $time, e.hit, rsp_hit);
               fail_count++;
            end
            if (rsp_frame !== e.frame) begin
               $display("%0t frame: expected %0d actual %0d", $time, e.frame, rsp_frame);
               fail_count++;
            end
            if (rsp_evicted_valid !== e.evicted_valid) begin
               $display("%0t evicted_valid: expected %0b actual %0b", $time,
                        e.evicted_valid, rsp_evicted_valid);
               fail_count++;
            end
            if (rsp_evicted_page !== e.evicted_page) begin
               $display("%0t evicted_page: expected %0h actual %0h", $time,
                        e.evicted_page, rsp_evicted_page);
               fail_count++;
            end
            if (rsp_fault_total !== e.fault_total) begin
               $display("%0t fault_total: expected %0d actual %0d", $time,
                        e.fault_total, rsp_fault_total);
               fail_count++;
            end
         end
      end
   end

   initial begin
      logic [FIU_BITS-1:0] phase_fiu [PHASES];
      logic [PAGE_W-1:0] pg;
      int idle_pct, ws, pick;
      reset = 1'b1;
      start = 1'b0;
      req_page = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      fail_count = 0;
      fault_tally = '0;
      frames_setting = FIU_RESET;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         page_held[i] = '0;
         frame_full[i] = 0;
         frame_age[i] = 0;
      end
      phase_fiu = '{4'd8, 4'd5, 4'd1, 4'd0, 4'd15, 4'd3, 4'd7, 4'd2, 4'd12, 4'd6,
                    4'd4, 4'd8};
      plan = '{
         chk(16'h0000, 0, 0, 0, 16'h0000, 1),
         chk(16'hFFFF, 0, 1, 0, 16'h0000, 2),
         chk(16'h0000, 1, 0, 0, 16'h0000, 2),
         chk(16'hAAAA, 0, 2, 0, 16'h0000, 3),
         chk(16'h5555, 0, 3, 0, 16'h0000, 4),
         chk(16'h0001, 0, 4, 0, 16'h0000, 5),
         chk(16'h0002, 0, 5, 0, 16'h0000, 6),
         chk(16'h0003, 0, 6, 0, 16'h0000, 7),
         chk(16'h0004, 0, 7, 0, 16'h0000, 8),
         // table full: oldest frame goes
         chk(16'h8000, 0, 1, 1, 16'hFFFF, 9),
         chk(16'h0000, 1, 0, 0, 16'h0000, 9),
         chk(16'h7FFF, 0, 2, 1, 16'hAAAA, 10),
         itm(16'h0003),
         // one frame only: page 4 lands in frame 0 while frame 7 still holds it
         cfg(4'd1),
         itm(16'h0004),
         itm(16'h0004),
         // above the frame count acts as full size; duplicate resolves to frame 0
         cfg(4'd15),
         itm(16'h0004),
         // zero acts as one frame
         cfg(4'd0),
         itm(16'hFFFF),
         itm(16'h0000),
         cfg(4'd8),
         itm(16'h5555),
         itm(16'h0001)
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) write_frames(plan[i].fiu);
         else send_page(plan[i].pg, plan[i].typed, plan[i].res, 0);
      end

      foreach (hot_pages[i]) hot_pages[i] = PAGE_W'($urandom);
      for (int ph = 0; ph < PHASES; ph++) begin
         write_frames(phase_fiu[ph]);
         idle_pct = (ph < 4) ? 22 : (ph < 8) ? 84 : 0;
         ws = $urandom_range(1, 12);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < 5) hot_pages[$urandom_range(0, 11)] = PAGE_W'($urandom);
            pick = $urandom_range(99);
            // mostly a small working set, so the table sees hits, fills and evictions
            if (pick < 75) pg = hot_pages[$urandom_range(0, ws - 1)];
            else if (pick < 92) pg = PAGE_W'($urandom);
            else if (pick < 96) pg = $urandom_range(1) ? '1 : '0;
            else pg = hot_pages[$urandom_range(0, 11)] ^ (PAGE_W'(1) << $urandom_range(0, 15));
            send_page(pg, 0, '0, idle_pct);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/lpr_pkg.sv
design/lpr_select.sv
design/lpr_rank.sv
design/lru_page_replacement_unit.sv
design/lpr_checker.sv
bench/tb_top.sv
